>>> hw/rtl/snr_pkg.sv
// Shared types and constants for the sequence gap NACK receiver.
// Result kinds, header function codes and front-to-back command codes.
// No dependencies.
`timescale 1ns / 1ps

package snr_pkg;

  localparam int SEQ_BITS_DEF   = 16;
  localparam int CMDQ_DEPTH_DEF = 4;
  localparam int OUTQ_DEPTH_DEF = 4;
  localparam int KIND_W         = 3;
  localparam int OP_W           = 3;
  localparam int DIV_TENTHS     = 10;
  localparam int DONE_VALUE     = 100;

  typedef enum logic [KIND_W-1:0] {
    KIND_STORE   = 3'd0,
    KIND_RETX    = 3'd1,
    KIND_PROG    = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_BADLEN  = 3'd4,
    KIND_OVERLAP = 3'd5,
    KIND_UNKNOWN = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_DATA  = 2'd1
  } func_t;

  typedef enum logic [OP_W-1:0] {
    OP_BADLEN  = 3'd0,
    OP_UNKNOWN = 3'd1,
    OP_START   = 3'd2,
    OP_LATE    = 3'd3,
    OP_DATA    = 3'd4
  } cmd_op_t;

endpackage

>>> hw/rtl/snr_fifo.sv
// Small register queue with full/empty flags, used between stages.
// Generic width and depth; no package dependency.
`timescale 1ns / 1ps

module snr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/snr_div.sv
// Restoring divider, one quotient bit per cycle.
// Used by the back end for progress checks; no package dependency.
`timescale 1ns / 1ps

module snr_div #(
  parameter int DW = 17,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int NW = $clog2(DW + 1);

  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [NW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  assign trial     = {rem_r, q_r[DW-1]};
  assign diff      = trial - {1'b0, dvs_r};
  assign ge        = (trial >= {1'b0, dvs_r});
  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= NW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == NW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[VW-1:0] : trial[VW-1:0];
      q_r   <= {q_r[DW-2:0], ge};
    end
  end

endmodule

>>> hw/rtl/snr_front.sv
// Front end: classifies each accepted header and tracks next expected sequence.
// Emits one command per header into the command queue. Uses snr_pkg.
`timescale 1ns / 1ps

module snr_front #(
  parameter int SEQ_BITS = 16,
  parameter int CMD_W    = snr_pkg::OP_W + 1 + 2 * SEQ_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic [1:0]          in_func,
  input  logic [SEQ_BITS-1:0] in_seq_number,
  input  logic                in_length_valid,
  input  logic                q_full,
  output logic                q_push,
  output logic [CMD_W-1:0]    q_data
);

  import snr_pkg::*;

  logic [SEQ_BITS:0]   next_r;
  logic [SEQ_BITS:0]   next_nxt;
  logic [SEQ_BITS:0]   seq_ext;
  cmd_op_t             op;
  logic                flag;

  assign seq_ext = {1'b0, in_seq_number};
  assign q_push  = in_push && !q_full;
  assign q_data  = {op, flag, in_seq_number, next_r[SEQ_BITS-1:0]};

  always_comb begin
    op       = OP_BADLEN;
    flag     = 1'b0;
    next_nxt = next_r;
    if (in_length_valid) begin
      unique case (func_t'(in_func))
        FUNC_START: begin
          op       = OP_START;
          flag     = (next_r != '0);
          next_nxt = '0;
        end
        FUNC_DATA: begin
          if (seq_ext < next_r) begin
            op = OP_LATE;
          end else begin
            op       = OP_DATA;
            flag     = (seq_ext != next_r);
            next_nxt = seq_ext + (SEQ_BITS + 1)'(1);
          end
        end
        default: begin
          op = OP_UNKNOWN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r <= '0;
    end else if (q_push) begin
      next_r <= next_nxt;
    end
  end

endmodule

>>> hw/rtl/snr_back.sv
// Back end: executes queued commands and pushes result records to the output queue.
// Holds total and tenth step; drives the divider for progress checks. Uses snr_pkg.
`timescale 1ns / 1ps

module snr_back #(
  parameter int SEQ_BITS = 16,
  parameter int CMD_W    = snr_pkg::OP_W + 1 + 2 * SEQ_BITS,
  parameter int RES_W    = snr_pkg::KIND_W + 2 * SEQ_BITS + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_empty,
  input  logic [CMD_W-1:0]    cmd_data,
  output logic                cmd_pop,
  output logic                div_start,
  output logic [SEQ_BITS:0]   div_dividend,
  output logic [SEQ_BITS-1:0] div_divisor,
  input  logic                div_done,
  input  logic [SEQ_BITS:0]   div_quot,
  input  logic [SEQ_BITS-1:0] div_rem,
  input  logic                res_full,
  output logic                res_push,
  output logic [RES_W-1:0]    res_data
);

  import snr_pkg::*;

  localparam int TENTH_SHIFT = SEQ_BITS + 3;
  localparam longint unsigned TENTH_RECIP =
    ((64'd1 << TENTH_SHIFT) + 64'(DIV_TENTHS - 1)) / 64'(DIV_TENTHS);
  localparam logic [SEQ_BITS-1:0] TENTH_RECIP_W = SEQ_BITS'(TENTH_RECIP);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [SEQ_BITS-1:0] total_r, total_nxt;
  logic [SEQ_BITS-1:0] step_r, step_nxt;
  kind_t               kind_r [3];
  kind_t               kind_nxt [3];
  logic [SEQ_BITS-1:0] val_r [3];
  logic [SEQ_BITS-1:0] val_nxt [3];
  logic [SEQ_BITS-1:0] end_r [3];
  logic [SEQ_BITS-1:0] end_nxt [3];
  logic [1:0]          cnt_r, cnt_nxt;
  logic [1:0]          idx_r, idx_nxt;

  cmd_op_t             c_op;
  logic                c_flag;
  logic [SEQ_BITS-1:0] c_seq;
  logic [SEQ_BITS-1:0] c_prev;
  logic [SEQ_BITS:0]   data_next;
  logic [1:0]          n;
  logic [2*SEQ_BITS-1:0] tenth_prod;
  logic [SEQ_BITS-1:0] tenth_q;

  assign c_op       = cmd_op_t'(cmd_data[CMD_W-1 -: OP_W]);
  assign c_flag     = cmd_data[2*SEQ_BITS];
  assign c_seq      = cmd_data[2*SEQ_BITS-1:SEQ_BITS];
  assign c_prev     = cmd_data[SEQ_BITS-1:0];
  assign data_next  = {1'b0, c_seq} + (SEQ_BITS + 1)'(1);
  assign tenth_prod = {SEQ_BITS'(0), c_seq} * {SEQ_BITS'(0), TENTH_RECIP_W};
  assign tenth_q    = SEQ_BITS'(tenth_prod >> TENTH_SHIFT);
  assign res_data   = {kind_r[idx_r], val_r[idx_r], end_r[idx_r], (idx_r == cnt_r - 2'd1)};

  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    step_nxt       = step_r;
    kind_nxt       = kind_r;
    val_nxt        = val_r;
    end_nxt        = end_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    n              = '0;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    div_start      = 1'b0;
    div_dividend   = '0;
    div_divisor    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          idx_nxt    = '0;
          val_nxt[0] = '0;
          end_nxt[0] = '0;
          cnt_nxt    = 2'd1;
          state_nxt  = S_EMIT;
          case (c_op)
            OP_BADLEN: begin
              kind_nxt[0] = KIND_BADLEN;
            end
            OP_UNKNOWN: begin
              kind_nxt[0] = KIND_UNKNOWN;
            end
            OP_LATE: begin
              kind_nxt[0] = KIND_STORE;
              val_nxt[0]  = c_seq;
            end
            OP_START: begin
              kind_nxt[0] = KIND_OVERLAP;
              cnt_nxt     = c_flag ? 2'd1 : 2'd0;
              total_nxt   = c_seq;
              step_nxt    = tenth_q;
              state_nxt   = c_flag ? S_EMIT : S_IDLE;
            end
            OP_DATA: begin
              if (c_flag) begin
                kind_nxt[0] = KIND_RETX;
                val_nxt[0]  = c_prev;
                end_nxt[0]  = c_seq - SEQ_BITS'(1);
                n           = 2'd1;
              end
              kind_nxt[n] = KIND_STORE;
              val_nxt[n]  = c_seq;
              end_nxt[n]  = '0;
              n           = n + 2'd1;
              if (data_next >= {1'b0, total_r}) begin
                kind_nxt[n] = KIND_DONE;
                val_nxt[n]  = SEQ_BITS'(DONE_VALUE);
                end_nxt[n]  = '0;
                n           = n + 2'd1;
              end else if (step_r != '0) begin
                div_start    = 1'b1;
                div_dividend = data_next;
                div_divisor  = step_r;
                state_nxt    = S_DIV;
              end
              cnt_nxt = n;
            end
            default: begin
              kind_nxt[0] = KIND_UNKNOWN;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            kind_nxt[cnt_r] = KIND_PROG;
            val_nxt[cnt_r]  = div_quot[SEQ_BITS-1:0];
            end_nxt[cnt_r]  = '0;
            cnt_nxt         = cnt_r + 2'd1;
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        res_push = !res_full;
        if (!res_full) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == cnt_r - 2'd1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      step_r  <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
    kind_r <= kind_nxt;
    val_r  <= val_nxt;
    end_r  <= end_nxt;
  end

endmodule

>>> hw/rtl/sequence_gap_nack_receiver.sv
// Top level of the sequence gap NACK receiver.
// Instantiates snr_front, snr_fifo, snr_back and snr_div; uses snr_pkg.
//
// Usage:
//   Headers enter as a queue push: in_func, in_seq_number, in_length_valid
//   transfer when in_push is high and in_full is low.
//   Results leave as a queue pop: the oldest result sits on out_kind, out_value,
//   out_range_end, out_last_result while out_empty is low; it transfers when
//   out_pop is high. out_last_result marks the final result of one header.
//   The front classifies a header in its accept cycle and queues a command.
//   The back takes one command at a time: it pops the command, then writes its
//   results to the output queue in order, holding while that queue is full; the
//   first result passes through the command queue and the back end's result
//   registers before the output queue. A data header that needs a progress check
//   also waits on the bit-serial divider before its results are written.
//   A start header sets the tenth step in the cycle it is taken.
//   Reset empties both queues and clears counters to zero.
//   When out_pop stays low the output queue fills, the back end holds, then
//   the command queue fills and in_full rises; nothing is dropped.
`timescale 1ns / 1ps

module sequence_gap_nack_receiver #(
  parameter int SEQ_BITS   = snr_pkg::SEQ_BITS_DEF,
  parameter int CMDQ_DEPTH = snr_pkg::CMDQ_DEPTH_DEF,
  parameter int OUTQ_DEPTH = snr_pkg::OUTQ_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_func,
  input  logic [SEQ_BITS-1:0] in_seq_number,
  input  logic                in_length_valid,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [2:0]          out_kind,
  output logic [SEQ_BITS-1:0] out_value,
  output logic [SEQ_BITS-1:0] out_range_end,
  output logic                out_last_result
);

  import snr_pkg::*;

  localparam int CMD_W = OP_W + 1 + 2 * SEQ_BITS;
  localparam int RES_W = KIND_W + 2 * SEQ_BITS + 1;

  logic                cmd_push;
  logic [CMD_W-1:0]    cmd_wr;
  logic                cmd_full;
  logic                cmd_pop;
  logic [CMD_W-1:0]    cmd_rd;
  logic                cmd_empty;
  logic                div_start;
  logic [SEQ_BITS:0]   div_dividend;
  logic [SEQ_BITS-1:0] div_divisor;
  logic                div_done;
  logic [SEQ_BITS:0]   div_quot;
  logic [SEQ_BITS-1:0] div_rem;
  logic                res_push;
  logic [RES_W-1:0]    res_wr;
  logic                res_full;
  logic [RES_W-1:0]    res_rd;

  assign in_full = cmd_full;
  assign {out_kind, out_value, out_range_end, out_last_result} = res_rd;

  snr_front #(
    .SEQ_BITS (SEQ_BITS),
    .CMD_W    (CMD_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_func         (in_func),
    .in_seq_number   (in_seq_number),
    .in_length_valid (in_length_valid),
    .q_full          (cmd_full),
    .q_push          (cmd_push),
    .q_data          (cmd_wr)
  );

  snr_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_wr),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  snr_back #(
    .SEQ_BITS (SEQ_BITS),
    .CMD_W    (CMD_W),
    .RES_W    (RES_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_empty    (cmd_empty),
    .cmd_data     (cmd_rd),
    .cmd_pop      (cmd_pop),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .div_rem      (div_rem),
    .res_full     (res_full),
    .res_push     (res_push),
    .res_data     (res_wr)
  );

  snr_div #(
    .DW (SEQ_BITS + 1),
    .VW (SEQ_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  snr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_rd),
    .empty   (out_empty)
  );

endmodule

>>> hw/rtl/snr_checker.sv
// Port-level checks for the sequence gap NACK receiver, bound to the top level.
// Uses snr_pkg result kinds.
`timescale 1ns / 1ps

module snr_checker #(
  parameter int SEQ_BITS = snr_pkg::SEQ_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_empty,
  input logic                out_pop,
  input logic [2:0]          out_kind,
  input logic [SEQ_BITS-1:0] out_value,
  input logic [SEQ_BITS-1:0] out_range_end,
  input logic                out_last_result
);

  import snr_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty)
    else $error("result queue not empty after reset");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_kind) &&
      $stable(out_value) && $stable(out_range_end) && $stable(out_last_result)))
    else $error("stalled result changed");

  a_retx_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_RETX) |-> !out_last_result)
    else $error("retransmit range marked as final result");

  a_range_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind != KIND_RETX) |-> (out_range_end == '0))
    else $error("range end nonzero outside retransmit result");

  a_done_value: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == KIND_DONE) |-> (out_value == SEQ_BITS'(DONE_VALUE) &&
      out_last_result))
    else $error("completion result malformed");

endmodule

bind sequence_gap_nack_receiver snr_checker #(.SEQ_BITS(SEQ_BITS)) u_snr_checker (.*);
